// ===== hdl/indexed_list_store_unit_assert.svh =====
// Assertion macros for the indexed list store unit.
// Included by modules that check their own logic; expects clk and rst_n in scope.
`ifndef INDEXED_LIST_STORE_UNIT_ASSERT_SVH
`define INDEXED_LIST_STORE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define ILSU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`define ILSU_ASSERT_NEXT(name, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`else

`define ILSU_ASSERT(name, prop, msg)

`define ILSU_ASSERT_NEXT(name, cond, conseq, msg)

`endif

`endif

// ===== hdl/ilsu_pkg.sv =====
// Shared types and constants for the indexed list store unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ilsu_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int VALUE_W        = 32;
    localparam int POS_W          = 5;
    localparam int COUNT_OUT_W    = 5;

    typedef enum logic [2:0] {
        F_PUSH_HEAD  = 3'd0,
        F_PUSH_TAIL  = 3'd1,
        F_INSERT     = 3'd2,
        F_POP_HEAD   = 3'd3,
        F_POP_TAIL   = 3'd4,
        F_REMOVE_AT  = 3'd5,
        F_READ       = 3'd6,
        F_CLEAR      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Broadcast command to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        func_t                     func;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_OUT_W-1:0]    entry_count;
        status_t                   status;
    } rsp_t;

endpackage

// ===== hdl/ilsu_cell.sv =====
// One storage cell of the list chain: holds one entry, shifts to/from neighbors.
// Depends on ilsu_pkg (cell_op_t).
`timescale 1ns / 1ps

module ilsu_cell import ilsu_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int IDX_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [IDX_W-1:0]      pos,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] rd_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit;
    logic                  above;

    assign hit   = (MY_IDX == pos);
    assign above = (MY_IDX > pos);

    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_INSERT:
            begin
                // open a gap at pos: take the left neighbor's word above it
                if (hit)
                    data_next = value;
                else if (above)
                    data_next = left;
            end
            CELL_REMOVE:
            begin
                // close the gap: pull the right neighbor's word down
                if (hit || above)
                    data_next = right;
            end
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = hit ? data_reg : '0;

endmodule

// ===== hdl/ilsu_skid.sv =====
// Two-entry output buffer: result register plus skid register.
// Depends on ilsu_pkg (rsp_t) and indexed_list_store_unit_assert.svh.
`timescale 1ns / 1ps
`include "indexed_list_store_unit_assert.svh"

module ilsu_skid import ilsu_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic load_valid,
    input  rsp_t load_word,
    output logic load_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    rsp_t out_word_reg;
    rsp_t out_word_next;
    rsp_t skid_word_reg;
    rsp_t skid_word_next;
    logic load_fire;
    logic rsp_fire;

    assign load_ready = !skid_valid_reg;
    assign load_fire  = load_valid && load_ready;
    assign rsp_fire   = out_valid_reg && rsp_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (rsp_fire)
            out_valid_next = 1'b0;
        // drain the skid word into the output register
        if (rsp_fire && skid_valid_reg)
        begin
            out_word_next   = skid_word_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        if (load_fire)
        begin
            if (!out_valid_reg || rsp_fire)
            begin
                out_word_next  = load_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = load_word;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

    `ILSU_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid word without output word")
    `ILSU_ASSERT_NEXT(a_skid_drains, rsp_fire && skid_valid_reg, out_valid_reg && !skid_valid_reg, "skid word not moved to output")
    `ILSU_ASSERT_NEXT(a_skid_catches, load_fire && out_valid_reg && !rsp_ready, skid_valid_reg, "stalled word not caught in skid")

endmodule

// ===== hdl/indexed_list_store_unit.sv =====
// Top level of the indexed list store: request decode, count, cell chain, output buffer.
// Depends on ilsu_pkg, ilsu_cell, ilsu_skid and indexed_list_store_unit_assert.svh.
//
//   channel | signals                    | word  | dir
//   --------+----------------------------+-------+-----
//   request | req_valid, req_ready, req  | req_t | in
//   result  | rsp_valid, rsp_ready, rsp  | rsp_t | out
//
// One request per clock while req_ready is high: decode and every cell's shift happen in
// the accept cycle; the result is registered in the output register, or in the skid
// register while the output one is held. The two registers hold two results; req_ready
// drops only while both are full, and rises again the cycle after rsp_ready takes one.
// Reset clears the entry count and the output buffer; cell contents are not reset.
`timescale 1ns / 1ps
`include "indexed_list_store_unit_assert.svh"

module indexed_list_store_unit import ilsu_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam logic [IDX_W-1:0] CAP_CNT = IDX_W'(CAPACITY);

    logic [IDX_W-1:0]      count_reg;
    logic [IDX_W-1:0]      count_next;
    logic [IDX_W-1:0]      count_op;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      cnt_c;
    logic [IDX_W-1:0]      pos_idx;
    status_t               status_c;
    cell_op_t              op_c;
    cell_op_t              cell_op;
    logic [IDX_W-1:0]      cell_pos;
    logic                  rd_ok;
    logic [DATA_WIDTH-1:0] wr_value;
    logic [DATA_WIDTH-1:0] rd_or;
    logic signed [DATA_WIDTH-1:0] rd_s;
    rsp_t                  rsp_c;

    logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd    [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_left  [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_right [CAPACITY];

    assign accept   = req_valid && req_ready;
    assign full     = (count_reg == CAP_CNT);
    assign empty    = (count_reg == '0);
    assign pos_c    = CMP_W'(req.position);
    assign cnt_c    = CMP_W'(count_reg);
    assign pos_idx  = IDX_W'(req.position);
    assign wr_value = DATA_WIDTH'(req.item_value);

    // decode one request into a chain command, new count and status
    always_comb
    begin
        status_c = ST_OK;
        op_c     = CELL_HOLD;
        cell_pos = '0;
        count_op = count_reg;
        rd_ok    = 1'b0;
        case (req.func)
            F_PUSH_HEAD, F_PUSH_TAIL:
            begin
                if (full)
                    status_c = ST_FULL;
                else
                begin
                    op_c     = CELL_INSERT;
                    cell_pos = (req.func == F_PUSH_HEAD) ? '0 : count_reg;
                    count_op = count_reg + 1'b1;
                end
            end
            F_INSERT:
            begin
                if (pos_c > cnt_c)
                    status_c = ST_BAD_INDEX;
                else if (full)
                    status_c = ST_FULL;
                else
                begin
                    op_c     = CELL_INSERT;
                    cell_pos = pos_idx;
                    count_op = count_reg + 1'b1;
                end
            end
            F_POP_HEAD, F_POP_TAIL:
            begin
                if (empty)
                    status_c = ST_EMPTY;
                else
                begin
                    // popping the back only drops the count
                    if (req.func == F_POP_HEAD)
                        op_c = CELL_REMOVE;
                    count_op = count_reg - 1'b1;
                end
            end
            F_REMOVE_AT, F_READ:
            begin
                cell_pos = pos_idx;
                if (empty)
                    status_c = ST_EMPTY;
                else if (pos_c >= cnt_c)
                    status_c = ST_BAD_INDEX;
                else if (req.func == F_REMOVE_AT)
                begin
                    op_c     = CELL_REMOVE;
                    count_op = count_reg - 1'b1;
                end
                else
                    rd_ok = 1'b1;
            end
            F_CLEAR:
            begin
                count_op = '0;
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    assign cell_op    = accept ? op_c : CELL_HOLD;
    assign count_next = accept ? count_op : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign cell_left[gi] = '0;
            end
            else
            begin : g_mid_left
                assign cell_left[gi] = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign cell_right[gi] = '0;
            end
            else
            begin : g_mid_right
                assign cell_right[gi] = cell_data[gi+1];
            end

            ilsu_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX_W      (IDX_W),
                .INDEX      (gi)
            ) u_cell (
                .clk     (clk),
                .op      (cell_op),
                .pos     (cell_pos),
                .value   (wr_value),
                .left    (cell_left[gi]),
                .right   (cell_right[gi]),
                .data    (cell_data[gi]),
                .rd_data (cell_rd[gi])
            );
        end
    endgenerate

    // only the addressed cell drives a nonzero read word
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_or = rd_or | cell_rd[i];
    end

    assign rd_s = rd_or;

    always_comb
    begin
        rsp_c.read_value  = rd_ok ? VALUE_W'(rd_s) : '0;
        rsp_c.entry_count = COUNT_OUT_W'(count_op);
        rsp_c.status      = status_c;
    end

    ilsu_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (req_valid),
        .load_word  (rsp_c),
        .load_ready (req_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

    `ILSU_ASSERT(a_count_bound, count_reg <= CAP_CNT, "entry count above capacity")
    `ILSU_ASSERT_NEXT(a_idle_holds, !accept,
        count_reg == $past(count_reg), "count moved without a request")
    `ILSU_ASSERT_NEXT(a_error_holds, accept && (status_c != ST_OK),
        count_reg == $past(count_reg), "failed request changed the count")
    `ILSU_ASSERT_NEXT(a_clear_empties, accept && (req.func == F_CLEAR),
        count_reg == '0, "clear left entries")

endmodule

// ===== sim/tb_indexed_list_store_unit.sv =====
// Self-checking testbench for indexed_list_store_unit: a shadow list predicts every result.
// Depends on ilsu_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module tb_indexed_list_store_unit import ilsu_pkg::*; ();

    localparam int LIST_DEPTH = DEF_CAPACITY;

    typedef enum int {
        WL_FILL  = 0,
        WL_MIXED = 1,
        WL_DRAIN = 2
    } workload_t;

    // Shadow copy of the list; holds the results still awaited from the block.
    class shadow_list;
        logic signed [VALUE_W-1:0] slots [LIST_DEPTH];
        int unsigned held;
        rsp_t awaited_results [$];
        int failures;

        function new();
            held = 0;
            failures = 0;
        endfunction

        function void open_gap(int unsigned at, logic signed [VALUE_W-1:0] value);
            for (int unsigned i = held; i > at; i--)
                slots[i] = slots[i - 1];
            slots[at] = value;
            held++;
        endfunction

        function void close_gap(int unsigned at);
            for (int unsigned i = at; i + 1 < held; i++)
                slots[i] = slots[i + 1];
            held--;
        endfunction

        function void apply_request(req_t r);
            rsp_t want;
            int unsigned at;
            want = '0;
            want.status = ST_OK;
            at = r.position;
            case (r.func)
                F_PUSH_HEAD, F_PUSH_TAIL:
                    if (held >= LIST_DEPTH)
                        want.status = ST_FULL;
                    else
                        open_gap((r.func == F_PUSH_HEAD) ? 0 : held, r.item_value);
                F_INSERT:
                    if (at > held)
                        want.status = ST_BAD_INDEX;
                    else if (held >= LIST_DEPTH)
                        want.status = ST_FULL;
                    else
                        open_gap(at, r.item_value);
                F_POP_HEAD, F_POP_TAIL:
                    if (held == 0)
                        want.status = ST_EMPTY;
                    else
                        close_gap((r.func == F_POP_HEAD) ? 0 : held - 1);
                F_REMOVE_AT, F_READ:
                    if (held == 0)
                        want.status = ST_EMPTY;
                    else if (at >= held)
                        want.status = ST_BAD_INDEX;
                    else if (r.func == F_REMOVE_AT)
                        close_gap(at);
                    else
                        want.read_value = slots[at];
                default:
                    held = 0;
            endcase
            want.entry_count = COUNT_OUT_W'(held);
            awaited_results.insert(awaited_results.size(), want);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (awaited_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] unexpected word: value %0d count %0d status %s",
                             $time, got.read_value, got.entry_count, got.status.name());
                return;
            end
            want = awaited_results[0];
            awaited_results.delete(0);
            if (got.read_value !== want.read_value || got.entry_count !== want.entry_count
                    || got.status !== want.status)
            begin
                failures++;
                if (failures <= 10)
                    $display({"[%0t] mismatch: want value %0d count %0d status %s,",
                              " got value %0d count %0d status %s"},
                             $time, want.read_value, want.entry_count, want.status.name(),
                             got.read_value, got.entry_count, got.status.name());
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    shadow_list board = new();
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int stall_left = 0;

    int op_weight [3][8] = '{
        '{22, 22, 22, 5, 5, 5, 16, 3},
        '{12, 12, 12, 12, 12, 13, 24, 3},
        '{7, 7, 7, 20, 20, 18, 18, 3}
    };

    indexed_list_store_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 93)
            return $urandom_range(4, 8);
        return $urandom_range(9, 24);
    endfunction

    // Result side: check each accepted word, then pick the next ready with random stalls.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_result(rsp);
        if (rst_n && stall_left == 0 && !rx_steady && $urandom_range(0, 99) < 20)
            stall_left = gap_length();
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else
            rsp_ready <= rst_n;
    end

    task automatic send_request(input req_t r);
        int gap;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 99) < 30)
            gap = gap_length();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        board.apply_request(r);
    endtask

    task automatic play_op(input func_t f, input logic [VALUE_W-1:0] value, input int at);
        req_t r;
        r.func = f;
        r.item_value = value;
        r.position = POS_W'(at);
        send_request(r);
    endtask

    // Drop valid and hold off until every awaited word has come back or the wait limit runs out.
    task automatic drain_results(input int limit);
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        while (board.awaited_results.size() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    function automatic func_t pick_func(input workload_t kind);
        int r;
        int acc;
        r = $urandom_range(0, 99);
        acc = 0;
        for (int i = 0; i < 8; i++)
        begin
            acc += op_weight[kind][i];
            if (r < acc)
                return func_t'(3'(i));
        end
        return F_CLEAR;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 32'h8000_0000;
        else if (r < 6)
            return 32'h7FFF_FFFF;
        else if (r < 8)
            return 32'hFFFF_FFFF;
        else if (r < 10)
            return 32'h0;
        return $urandom();
    endfunction

    function automatic int pick_position();
        int r;
        int h;
        r = $urandom_range(0, 99);
        h = board.held;
        if (r < 70)
            return $urandom_range(0, h);
        else if (r < 85)
            return $urandom_range((h > 0) ? h - 1 : 0, h);
        return $urandom_range(0, 31);
    endfunction

    initial
    begin
        workload_t plan [5];
        req_t r;
        int fail_total;
        plan = '{WL_FILL, WL_MIXED, WL_DRAIN, WL_FILL, WL_MIXED};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, bad indices, extremes of the word, shifts in the middle.
        play_op(F_READ, 32'h1234_5678, 0);
        play_op(F_POP_HEAD, 32'h0, 0);
        play_op(F_POP_TAIL, 32'h0, 0);
        play_op(F_REMOVE_AT, 32'h0, 31);
        play_op(F_INSERT, 32'h1, 1);
        play_op(F_INSERT, 32'h7FFF_FFFF, 0);
        play_op(F_PUSH_HEAD, 32'h8000_0000, 0);
        play_op(F_PUSH_TAIL, 32'hFFFF_FFFF, 0);
        play_op(F_PUSH_TAIL, 32'h0, 0);
        play_op(F_INSERT, 32'h5555_5555, 4);
        play_op(F_INSERT, 32'hAAAA_AAAA, 2);
        play_op(F_READ, 32'h0, 0);
        play_op(F_READ, 32'h0, 5);
        play_op(F_READ, 32'h0, 6);
        play_op(F_READ, 32'h0, 16);
        play_op(F_READ, 32'h0, 31);
        play_op(F_REMOVE_AT, 32'h0, 6);
        play_op(F_REMOVE_AT, 32'h0, 2);
        play_op(F_POP_HEAD, 32'h0, 0);
        play_op(F_POP_TAIL, 32'h0, 0);
        play_op(F_READ, 32'h0, 1);
        play_op(F_CLEAR, 32'h0, 0);
        play_op(F_CLEAR, 32'h0, 0);
        play_op(F_READ, 32'h0, 0);
        drain_results(5000);

        for (int p = 0; p < 5; p++)
        begin
            tx_steady = (p == 1);
            rx_steady = (p == 1) || (p == 3);
            for (int n = 0; n < 110; n++)
            begin
                r.func = pick_func(plan[p]);
                r.item_value = pick_value();
                r.position = POS_W'(pick_position());
                send_request(r);
            end
            drain_results(5000);
        end

        repeat (8) @(posedge clk);
        fail_total = board.failures + board.awaited_results.size();
        if (fail_total == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== indexed_list_store_unit.f =====
+incdir+hdl
hdl/ilsu_pkg.sv
hdl/ilsu_cell.sv
hdl/ilsu_skid.sv
hdl/indexed_list_store_unit.sv
sim/tb_indexed_list_store_unit.sv
